@@ hdl/tiler_pkg.sv @@
package tiler_pkg;

    localparam int CFG_W = 9;
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_COUNT   = 2'd2;

    localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET  = 9'd256;
    localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RESET = 9'd256;
    localparam logic [CFG_W-1:0] TILE_COUNT_RESET   = 9'd1;

    typedef struct packed {
        logic div_start;
        logic div_row;
        logic div_capture;
        logic load;
        logic emit;
        logic out_capture;
    } tiler_cmd_t;

    typedef struct packed {
        logic cfg_write;
        logic div_done;
        logic loaded;
    } tiler_status_t;

endpackage

@@ hdl/image_nxn_tiler_top.sv @@
// One load beat can be accepted every cycle while in_stall is low.
// An emit beat's pixel passes through the registered read of the frame store and then the output
// register; input is stalled in the read state, so no new beat is taken until that read is done.
// After reset and after each register write, a setup runs two serial divisions on one
// shared divider for the tile sizes while input is stalled.
// Reset sets the registers to 256, 256 and 1; the frame store is not cleared.
module image_nxn_tiler_top
    import tiler_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [PIXEL_BITS-1:0] pixel_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIXEL_BITS-1:0] pixel_out,
    output logic                  frame_last
);

    tiler_cmd_t    cmd;
    tiler_status_t status;

    assign pready = 1'b1;

    tiler_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tiler_datapath #(
        .MAX_DIM    (MAX_DIM),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pixel_in   (pixel_in),
        .cmd        (cmd),
        .status     (status),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

endmodule

@@ hdl/tiler_ram.sv @@
module tiler_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/tiler_div.sv @@
module tiler_div #(
    parameter int NUM_W = 9,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem,
    output logic             done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   partial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb
    begin
        partial   = {rem_reg, num_reg[NUM_W-1]};
        diff      = partial - {1'b0, den_reg};
        fits      = partial >= {1'b0, den_reg};
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quot = num_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

@@ hdl/tiler_axis.sv @@
module tiler_axis
    import tiler_pkg::*;
#(
    parameter int DW = 9,
    parameter int AW = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             step,
    input  logic [DW-1:0]    dim,
    input  logic [DW-1:0]    tile_small,
    input  logic [CFG_W-1:0] big_count,
    input  logic [AW-1:0]    scale,
    output logic [AW-1:0]    acc,
    output logic             at_end
);

    logic [DW-1:0]    pos_reg, pos_next;
    logic [DW-1:0]    off_reg, off_next;
    logic [CFG_W-1:0] tile_reg, tile_next;
    logic [AW-1:0]    acc_reg, acc_next;
    logic             big;
    logic [DW-1:0]    len_m1;

    always_comb
    begin
        big       = tile_reg < big_count;
        len_m1    = big ? tile_small : tile_small - DW'(1);
        at_end    = pos_reg == dim - DW'(1);
        pos_next  = pos_reg;
        off_next  = off_reg;
        tile_next = tile_reg;
        acc_next  = acc_reg;
        if (clear || (step && at_end))
        begin
            pos_next  = '0;
            off_next  = '0;
            tile_next = '0;
            acc_next  = '0;
        end
        else if (step)
        begin
            pos_next = pos_reg + DW'(1);
            if (off_reg == len_m1)
            begin
                off_next = '0;
                acc_next = '0;
                if (big)
                begin
                    tile_next = tile_reg + CFG_W'(1);
                end
            end
            else
            begin
                off_next = off_reg + DW'(1);
                acc_next = acc_reg + scale;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            off_reg  <= '0;
            tile_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            off_reg  <= off_next;
            tile_reg <= tile_next;
            acc_reg  <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

@@ hdl/tiler_datapath.sv @@
module tiler_datapath
    import tiler_pkg::*;
#(
    parameter int MAX_DIM    = 256,
    parameter int PIXEL_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    input  logic [PIXEL_BITS-1:0] pixel_in,
    input  tiler_cmd_t            cmd,
    output tiler_status_t         status,
    output logic [PIXEL_BITS-1:0] pixel_out,
    output logic                  frame_last
);

    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0]      width_reg, height_reg, tiles_reg;
    logic [DW-1:0]         weff, heff;
    logic [CFG_W-1:0]      neff;
    logic                  wr_en;
    logic [1:0]            reg_index;
    logic                  cfg_write;

    logic [AW:0]           total_reg, total_next;
    logic [AW-1:0]         nw_reg, nw_next;
    logic [AW-1:0]         load_index_reg, load_index_next;
    logic [AW:0]           load_inc;
    logic                  loaded_reg, loaded_next;

    logic [DW-1:0]         div_num;
    logic [DW-1:0]         div_quot;
    logic [CFG_W-1:0]      div_rem;
    logic                  div_done;
    logic [DW-1:0]         col_small_reg, row_small_reg;
    logic [CFG_W-1:0]      col_big_reg, row_big_reg;

    logic                  axis_clear;
    logic                  row_step;
    logic [AW-1:0]         col_acc, row_acc;
    logic                  col_end, row_end;
    logic [AW-1:0]         raddr;
    logic [PIXEL_BITS-1:0] rdata;
    logic                  last_pend_reg;
    logic [PIXEL_BITS-1:0] pixel_out_reg;
    logic                  frame_last_reg;

    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        cfg_write = 1'b0;
        if (wr_en)
        begin
            unique case (reg_index)
                REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_TILE_COUNT: cfg_write = 1'b1;
                default: cfg_write = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
            tiles_reg  <= TILE_COUNT_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                REG_TILE_COUNT:   tiles_reg  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(height_reg);
            REG_TILE_COUNT:   prdata = APB_DATA_W'(tiles_reg);
            default:          prdata = '0;
        endcase
    end

    // Out-of-range sizes are clamped: zero acts as one, oversize as the maximum; a tile count of zero acts as one.
    always_comb
    begin
        weff = (width_reg == '0) ? DW'(1)
             : (32'(width_reg) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(width_reg);
        heff = (height_reg == '0) ? DW'(1)
             : (32'(height_reg) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(height_reg);
        neff = (tiles_reg == '0) ? CFG_W'(1) : tiles_reg;
        total_next = (AW + 1)'(weff) * (AW + 1)'(heff);
        nw_next    = AW'(neff) * AW'(weff);
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        nw_reg    <= nw_next;
    end

    assign div_num = cmd.div_row ? heff : weff;

    tiler_div #(
        .NUM_W (DW),
        .DEN_W (CFG_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (neff),
        .quot  (div_quot),
        .rem   (div_rem),
        .done  (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_capture)
        begin
            if (cmd.div_row)
            begin
                row_small_reg <= div_quot;
                row_big_reg   <= div_rem;
            end
            else
            begin
                col_small_reg <= div_quot;
                col_big_reg   <= div_rem;
            end
        end
    end

    // A load into a completed frame starts a new one at raster index zero.
    always_comb
    begin
        load_inc        = {1'b0, load_index_reg} + (AW + 1)'(1);
        load_index_next = load_index_reg;
        loaded_next     = loaded_reg;
        if (cfg_write)
        begin
            load_index_next = '0;
            loaded_next     = 1'b0;
        end
        else if (cmd.load)
        begin
            if (load_inc >= total_reg)
            begin
                load_index_next = '0;
                loaded_next     = 1'b1;
            end
            else
            begin
                load_index_next = load_inc[AW-1:0];
                loaded_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
            loaded_reg     <= 1'b0;
        end
        else
        begin
            load_index_reg <= load_index_next;
            loaded_reg     <= loaded_next;
        end
    end

    assign axis_clear = cfg_write || (cmd.load && loaded_reg);
    assign row_step   = cmd.emit && col_end;

    tiler_axis #(
        .DW (DW),
        .AW (AW)
    ) u_col_axis (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (axis_clear),
        .step       (cmd.emit),
        .dim        (weff),
        .tile_small (col_small_reg),
        .big_count  (col_big_reg),
        .scale      (AW'(neff)),
        .acc        (col_acc),
        .at_end     (col_end)
    );

    tiler_axis #(
        .DW (DW),
        .AW (AW)
    ) u_row_axis (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (axis_clear),
        .step       (row_step),
        .dim        (heff),
        .tile_small (row_small_reg),
        .big_count  (row_big_reg),
        .scale      (nw_reg),
        .acc        (row_acc),
        .at_end     (row_end)
    );

    assign raddr = row_acc + col_acc;

    tiler_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (cmd.load),
        .waddr (load_index_reg),
        .wdata (pixel_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            last_pend_reg <= row_end && col_end;
        end
        if (cmd.out_capture)
        begin
            pixel_out_reg  <= rdata;
            frame_last_reg <= last_pend_reg;
        end
    end

    assign pixel_out  = pixel_out_reg;
    assign frame_last = frame_last_reg;

    assign status.cfg_write = cfg_write;
    assign status.div_done  = div_done;
    assign status.loaded    = loaded_reg;

endmodule

@@ hdl/tiler_ctrl.sv @@
module tiler_ctrl
    import tiler_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          req_type,
    output logic          out_valid,
    input  logic          out_stall,
    input  tiler_status_t status,
    output tiler_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_DIV_COL,
        S_WAIT_COL,
        S_DIV_ROW,
        S_WAIT_ROW,
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_accept;

    always_comb
    begin
        in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
        in_accept = in_valid && !in_stall;

        cmd.div_start   = (state_reg == S_DIV_COL) || (state_reg == S_DIV_ROW);
        cmd.div_row     = (state_reg == S_DIV_ROW) || (state_reg == S_WAIT_ROW);
        cmd.div_capture = ((state_reg == S_WAIT_COL) || (state_reg == S_WAIT_ROW))
                          && status.div_done;
        cmd.load        = in_accept && !req_type;
        cmd.emit        = in_accept && req_type && status.loaded;
        cmd.out_capture = state_reg == S_READ;

        state_next = state_reg;
        unique case (state_reg)
            S_DIV_COL:  state_next = S_WAIT_COL;
            S_WAIT_COL: if (status.div_done) state_next = S_DIV_ROW;
            S_DIV_ROW:  state_next = S_WAIT_ROW;
            S_WAIT_ROW: if (status.div_done) state_next = S_IDLE;
            S_IDLE:     if (cmd.emit) state_next = S_READ;
            S_READ:     state_next = S_IDLE;
            default:    state_next = S_DIV_COL;
        endcase
        if (status.cfg_write)
        begin
            state_next = S_DIV_COL;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_DIV_COL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
